[rtl/core/hlg_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the hexagonal lattice gas step block.
package hlg_pkg;

    typedef enum logic [1:0] {
        OP_TBL_WR  = 2'd0,
        OP_CELL_WR = 2'd1,
        OP_STEP    = 2'd2,
        OP_CELL_RD = 2'd3
    } t_opcode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CELL_OUT,
        S_SWEEP,
        S_SWEEP_END,
        S_RD_CELL,
        S_GET_CELL,
        S_GET_ST,
        S_DIR,
        S_NB_RD,
        S_SELF_RD,
        S_SELF_WR,
        S_INJ_RD,
        S_INJ_WR
    } t_state;

    typedef logic [2:0] t_dir;

    typedef struct packed {
        logic vert_out;
        logic horiz_out;
    } t_nbr_flags;

    typedef struct packed {
        logic       strobe;
        t_opcode    opcode;
        logic [6:0] bits;
        logic       wall;
    } t_result;

    // Size register indexes on the write channel
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;

    localparam int         WALL_BIT    = 7;
    localparam int         REST_BIT    = 6;
    localparam logic [6:0] INJECT_MASK = 7'h23;
    localparam t_dir       LAST_DIR    = 3'd5;

    // One-hot bit of the direction opposite to d
    function automatic logic [6:0] back_bit(input t_dir d);
        logic [6:0] b;
        case (d)
            3'd0:    b = 7'h08;
            3'd1:    b = 7'h10;
            3'd2:    b = 7'h20;
            3'd3:    b = 7'h01;
            3'd4:    b = 7'h02;
            3'd5:    b = 7'h04;
            default: b = 7'h00;
        endcase
        return b;
    endfunction

    function automatic logic [6:0] dir_bit(input t_dir d);
        logic [6:0] b;
        case (d)
            3'd0:    b = 7'h01;
            3'd1:    b = 7'h02;
            3'd2:    b = 7'h04;
            3'd3:    b = 7'h08;
            3'd4:    b = 7'h10;
            3'd5:    b = 7'h20;
            default: b = 7'h00;
        endcase
        return b;
    endfunction

endpackage

[rtl/core/hlg_grid_ram.sv]
`timescale 1ns / 1ps
// Dual-bank grid store: one write port, one registered read port.
module hlg_grid_ram #(
    parameter int AW = 13
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);
    logic [7:0] r_mem [0:(2**AW)-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/core/hlg_ctable.sv]
`timescale 1ns / 1ps
// Collision table: 128 entries of 7 bits, registered read.
module hlg_ctable (
    input  logic       i_clk,
    input  logic       i_we,
    input  logic [6:0] i_waddr,
    input  logic [6:0] i_wdata,
    input  logic [6:0] i_raddr,
    output logic [6:0] o_rdata
);
    logic [6:0] r_mem [0:127];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/core/hlg_nbr.sv]
`timescale 1ns / 1ps
// Neighbour unit: target coordinates and edge flags for one direction.
module hlg_nbr #(
    parameter int XW = 6,
    parameter int YW = 6
) (
    input  logic [XW-1:0]      i_x,
    input  logic [YW-1:0]      i_y,
    input  hlg_pkg::t_dir      i_d,
    input  logic [XW:0]        i_w,
    input  logic [YW:0]        i_h,
    output logic [XW-1:0]      o_nx,
    output logic [YW-1:0]      o_ny,
    output hlg_pkg::t_nbr_flags o_flags
);
    always_comb begin
        int ix;
        int iy;
        int odd;
        ix  = int'({1'b0, i_x});
        iy  = int'({1'b0, i_y});
        odd = int'({1'b0, i_y[0]});
        case (i_d)
            3'd0: ix = ix + 1;
            3'd1: begin ix = ix + odd;     iy = iy - 1; end
            3'd2: begin ix = ix + odd - 1; iy = iy - 1; end
            3'd3: ix = ix - 1;
            3'd4: begin ix = ix + odd - 1; iy = iy + 1; end
            default: begin ix = ix + odd;  iy = iy + 1; end
        endcase
        o_flags.vert_out  = (iy < 0) || (iy >= int'({1'b0, i_h}));
        o_flags.horiz_out = (ix < 0) || (ix >= int'({1'b0, i_w}));
        o_nx = ix[XW-1:0];
        o_ny = iy[YW-1:0];
    end
endmodule

[rtl/core/hlg_seq.sv]
`timescale 1ns / 1ps
// Command sequencer: table and cell access, three-pass step over the shared grid port.
module hlg_seq #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  hlg_pkg::t_opcode     i_opcode,
    input  logic [5:0]           i_cell_x,
    input  logic [5:0]           i_cell_y,
    input  logic [6:0]           i_cell_bits,
    input  logic                 i_cell_is_wall,
    input  logic [6:0]           i_table_index,
    input  logic [6:0]           i_table_value,
    input  logic [$clog2(MAX_WIDTH):0]  i_w,
    input  logic [$clog2(MAX_HEIGHT):0] i_h,
    output logic                 o_busy,
    output hlg_pkg::t_result     o_result
);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int CW    = $clog2(CELLS);
    localparam int AW    = CW + 1;
    localparam logic [XW-1:0] XMAX = XW'(MAX_WIDTH - 1);
    localparam logic [YW-1:0] YMAX = YW'(MAX_HEIGHT - 1);

    function automatic logic [CW-1:0] cidx(input logic [31:0] x, input logic [31:0] y);
        logic [31:0] t;
        t = y * 32'(MAX_WIDTH) + x;
        return t[CW-1:0];
    endfunction

    hlg_pkg::t_state r_state, n_state;
    logic [XW-1:0] r_x, n_x, r_px, n_px;
    logic [YW-1:0] r_y, n_y, r_py, n_py;
    hlg_pkg::t_dir r_d, n_d;
    logic [6:0]    r_st, n_st, r_self, n_self;
    logic          r_live, n_live, r_pv, n_pv, r_inside, n_inside;
    hlg_pkg::t_result r_res, n_res;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wdata, rdata;
    logic          t_we;
    logic [6:0]    t_raddr, t_rdata;
    logic [XW-1:0] nx;
    logic [YW-1:0] ny;
    hlg_pkg::t_nbr_flags nflags;
    logic          last_cell, last_row, last_dir, in_acc, cmd_inside;

    hlg_grid_ram #(.AW(AW)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    hlg_ctable u_tbl (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(i_table_index), .i_wdata(i_table_value),
        .i_raddr(t_raddr), .o_rdata(t_rdata)
    );

    hlg_nbr #(.XW(XW), .YW(YW)) u_nbr (
        .i_x(r_x), .i_y(r_y), .i_d(r_d), .i_w(i_w), .i_h(i_h),
        .o_nx(nx), .o_ny(ny), .o_flags(nflags)
    );

    assign o_busy     = (r_state != hlg_pkg::S_IDLE);
    assign o_result   = r_res;
    assign last_row   = ({1'b0, r_y} + 1'b1) == i_h;
    assign last_cell  = (({1'b0, r_x} + 1'b1) == i_w) && last_row;
    assign last_dir   = (r_d == hlg_pkg::LAST_DIR);
    assign in_acc     = ({1'b0, r_px} < i_w) && ({1'b0, r_py} < i_h);
    assign cmd_inside = (32'(i_cell_x) < 32'(MAX_WIDTH)) && (32'(i_cell_y) < 32'(MAX_HEIGHT));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            hlg_pkg::S_IDLE: begin
                if (i_accept && i_opcode == hlg_pkg::OP_STEP) begin
                    n_state = hlg_pkg::S_SWEEP;
                end else if (i_accept && i_opcode == hlg_pkg::OP_CELL_RD) begin
                    n_state = hlg_pkg::S_CELL_OUT;
                end
            end
            hlg_pkg::S_CELL_OUT: n_state = hlg_pkg::S_IDLE;
            hlg_pkg::S_SWEEP: begin
                if (r_x == XMAX && r_y == YMAX) n_state = hlg_pkg::S_SWEEP_END;
            end
            hlg_pkg::S_SWEEP_END: n_state = hlg_pkg::S_RD_CELL;
            hlg_pkg::S_RD_CELL:   n_state = hlg_pkg::S_GET_CELL;
            hlg_pkg::S_GET_CELL: begin
                if (!rdata[hlg_pkg::WALL_BIT]) n_state = hlg_pkg::S_GET_ST;
                else if (last_cell)            n_state = hlg_pkg::S_INJ_RD;
                else                           n_state = hlg_pkg::S_RD_CELL;
            end
            hlg_pkg::S_GET_ST: n_state = hlg_pkg::S_DIR;
            hlg_pkg::S_DIR: begin
                if (r_st[r_d] && !nflags.vert_out && !nflags.horiz_out) begin
                    n_state = hlg_pkg::S_NB_RD;
                end else if (last_dir) begin
                    n_state = hlg_pkg::S_SELF_RD;
                end
            end
            hlg_pkg::S_NB_RD:   n_state = last_dir ? hlg_pkg::S_SELF_RD : hlg_pkg::S_DIR;
            hlg_pkg::S_SELF_RD: n_state = hlg_pkg::S_SELF_WR;
            hlg_pkg::S_SELF_WR: n_state = last_cell ? hlg_pkg::S_INJ_RD : hlg_pkg::S_RD_CELL;
            hlg_pkg::S_INJ_RD:  n_state = hlg_pkg::S_INJ_WR;
            hlg_pkg::S_INJ_WR:  n_state = last_row ? hlg_pkg::S_IDLE : hlg_pkg::S_INJ_RD;
            default:            n_state = hlg_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        logic [CW-1:0] here;
        here     = cidx(32'(r_x), 32'(r_y));
        n_x      = r_x;
        n_y      = r_y;
        n_px     = r_x;
        n_py     = r_y;
        n_pv     = 1'b0;
        n_d      = r_d;
        n_st     = r_st;
        n_self   = r_self;
        n_live   = r_live;
        n_inside = r_inside;
        n_res    = '{strobe: 1'b0, opcode: r_res.opcode, bits: 7'd0, wall: 1'b0};
        we       = 1'b0;
        waddr    = {~r_live, here};
        wdata    = 8'd0;
        raddr    = {r_live, here};
        t_we     = 1'b0;
        t_raddr  = rdata[6:0];

        case (r_state)
            hlg_pkg::S_IDLE: begin
                raddr = {r_live, cidx(32'(i_cell_x), 32'(i_cell_y))};
                waddr = {r_live, cidx(32'(i_cell_x), 32'(i_cell_y))};
                wdata = {i_cell_is_wall, i_cell_bits};
                n_inside = cmd_inside;
                n_x = '0;
                n_y = '0;
                if (i_accept) begin
                    n_res.opcode = i_opcode;
                    case (i_opcode)
                        hlg_pkg::OP_TBL_WR: begin
                            t_we = 1'b1;
                            n_res.strobe = 1'b1;
                        end
                        hlg_pkg::OP_CELL_WR: begin
                            we = cmd_inside;
                            n_res.strobe = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            hlg_pkg::S_CELL_OUT: begin
                n_res.strobe = 1'b1;
                n_res.bits   = r_inside ? rdata[6:0] : 7'd0;
                n_res.wall   = r_inside & rdata[hlg_pkg::WALL_BIT];
            end
            hlg_pkg::S_SWEEP, hlg_pkg::S_SWEEP_END: begin
                // copy pass: in-use cells keep only the obstacle flag
                waddr = {~r_live, cidx(32'(r_px), 32'(r_py))};
                we    = r_pv;
                wdata = in_acc ? {rdata[hlg_pkg::WALL_BIT], 7'd0} : rdata;
                if (r_state == hlg_pkg::S_SWEEP) begin
                    n_pv = 1'b1;
                    if (r_x == XMAX) begin
                        n_x = '0;
                        n_y = r_y + 1'b1;
                    end else begin
                        n_x = r_x + 1'b1;
                    end
                end else begin
                    n_x = '0;
                    n_y = '0;
                end
            end
            hlg_pkg::S_GET_CELL: begin
                if (rdata[hlg_pkg::WALL_BIT]) begin
                    if (({1'b0, r_x} + 1'b1) == i_w) begin
                        n_x = '0;
                        n_y = last_row ? '0 : r_y + 1'b1;
                    end else begin
                        n_x = r_x + 1'b1;
                    end
                end
            end
            hlg_pkg::S_GET_ST: begin
                n_st   = t_rdata;
                n_self = t_rdata & (7'd1 << hlg_pkg::REST_BIT);
                n_d    = '0;
            end
            hlg_pkg::S_DIR: begin
                raddr = {~r_live, cidx(32'(nx), 32'(ny))};
                if (r_st[r_d] && nflags.vert_out) begin
                    n_self = r_self | hlg_pkg::back_bit(r_d);
                end
                if (!(r_st[r_d] && !nflags.vert_out && !nflags.horiz_out) && !last_dir) begin
                    n_d = r_d + 1'b1;
                end
            end
            hlg_pkg::S_NB_RD: begin
                waddr = {~r_live, cidx(32'(nx), 32'(ny))};
                wdata = rdata | {1'b0, hlg_pkg::dir_bit(r_d)};
                if (rdata[hlg_pkg::WALL_BIT]) begin
                    n_self = r_self | hlg_pkg::back_bit(r_d);
                end else begin
                    we = 1'b1;
                end
                if (!last_dir) n_d = r_d + 1'b1;
            end
            hlg_pkg::S_SELF_RD: begin
                raddr = {~r_live, here};
            end
            hlg_pkg::S_SELF_WR: begin
                we    = 1'b1;
                wdata = rdata | {1'b0, r_self};
                if (({1'b0, r_x} + 1'b1) == i_w) begin
                    n_x = '0;
                    n_y = last_row ? '0 : r_y + 1'b1;
                end else begin
                    n_x = r_x + 1'b1;
                end
            end
            hlg_pkg::S_INJ_RD: begin
                raddr = {~r_live, here};
            end
            hlg_pkg::S_INJ_WR: begin
                we    = !rdata[hlg_pkg::WALL_BIT];
                wdata = rdata | {1'b0, hlg_pkg::INJECT_MASK};
                n_y   = r_y + 1'b1;
                if (last_row) begin
                    n_live       = ~r_live;
                    n_res.strobe = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= hlg_pkg::S_IDLE;
            r_live       <= 1'b0;
            r_pv         <= 1'b0;
            r_res.strobe <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_live       <= n_live;
            r_pv         <= n_pv;
            r_res.strobe <= n_res.strobe;
        end
        r_res.opcode <= n_res.opcode;
        r_res.bits   <= n_res.bits;
        r_res.wall   <= n_res.wall;
        r_x      <= n_x;
        r_y      <= n_y;
        r_px     <= n_px;
        r_py     <= n_py;
        r_d      <= n_d;
        r_st     <= n_st;
        r_self   <= n_self;
        r_inside <= n_inside;
    end
endmodule

[rtl/core/hex_lattice_gas_step.sv]
`timescale 1ns / 1ps
// Top level of the hexagonal lattice gas step block.
//
// One command item is taken when i_start is high and o_busy low; each item
// gives exactly one result, shown for a single cycle with o_done high, and the
// receiver cannot hold it off. A step makes a copy pass over the whole
// store, then a collide-and-stream pass over the in-use cells, then an
// injection pass over the in-use rows; all three passes share the single
// read and write port of the grid store.
// The size registers are taken on a write channel that is always ready and
// should only be written while the block is idle.
module hex_lattice_gas_step #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output logic       o_busy,
    input  logic [1:0] i_opcode,
    input  logic [5:0] i_cell_x,
    input  logic [5:0] i_cell_y,
    input  logic [6:0] i_cell_bits,
    input  logic       i_cell_is_wall,
    input  logic [6:0] i_table_index,
    input  logic [6:0] i_table_value,
    output logic       o_done,
    output logic [1:0] o_done_opcode,
    output logic [6:0] o_read_bits,
    output logic       o_read_is_wall,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [6:0] i_cfg_data
);
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);

    logic [6:0] r_grid_width, r_grid_height;
    logic [XW:0] w_eff;
    logic [YW:0] h_eff;
    logic [31:0] w_tmp, h_tmp;
    hlg_pkg::t_result res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= 7'd64;
            r_grid_height <= 7'd64;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == hlg_pkg::CFG_WIDTH)  r_grid_width  <= i_cfg_data;
            if (i_cfg_index == hlg_pkg::CFG_HEIGHT) r_grid_height <= i_cfg_data;
        end
    end

    // zero acts as one, oversize as the store size
    always_comb begin
        w_tmp = 32'(r_grid_width);
        h_tmp = 32'(r_grid_height);
        if (w_tmp == 32'd0) w_tmp = 32'd1;
        if (w_tmp > 32'(MAX_WIDTH)) w_tmp = 32'(MAX_WIDTH);
        if (h_tmp == 32'd0) h_tmp = 32'd1;
        if (h_tmp > 32'(MAX_HEIGHT)) h_tmp = 32'(MAX_HEIGHT);
    end
    assign w_eff = w_tmp[XW:0];
    assign h_eff = h_tmp[YW:0];

    hlg_seq #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_accept(i_start & ~o_busy),
        .i_opcode(hlg_pkg::t_opcode'(i_opcode)),
        .i_cell_x(i_cell_x), .i_cell_y(i_cell_y),
        .i_cell_bits(i_cell_bits), .i_cell_is_wall(i_cell_is_wall),
        .i_table_index(i_table_index), .i_table_value(i_table_value),
        .i_w(w_eff), .i_h(h_eff),
        .o_busy(o_busy), .o_result(res)
    );

    assign o_done         = res.strobe;
    assign o_done_opcode  = res.opcode;
    assign o_read_bits    = res.bits;
    assign o_read_is_wall = res.wall;
endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for hex_lattice_gas_step with a built-in lattice gas predictor.
module tb;

    localparam int GW       = 64;       // store width, as the block's default
    localparam int GH       = 64;
    localparam int NCELLS   = GW * GH;
    localparam int TAIL     = 20;       // quiet cycles after the last result
    localparam int LIMIT    = 3000000;  // generous: well above what a full-size step takes
    localparam int NPAT     = 12;       // cell patterns whose table entries get loaded

    typedef enum int { K_CMD, K_CFG, K_DRAIN } t_kind;

    typedef struct {
        t_kind            kind;
        hlg_pkg::t_opcode op;
        logic [5:0]       x;
        logic [5:0]       y;
        logic [6:0]       bits;
        logic             wall;
        logic [6:0]       tidx;
        logic [6:0]       tval;
        logic [1:0]       reg_idx;
        logic [6:0]       reg_data;
    } t_item;

    typedef struct {
        hlg_pkg::t_opcode op;
        logic [6:0]       bits;
        logic             wall;
    } t_answer;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_start = 1'b0;
    logic [1:0] i_opcode = '0;
    logic [5:0] i_cell_x = '0;
    logic [5:0] i_cell_y = '0;
    logic [6:0] i_cell_bits = '0;
    logic       i_cell_is_wall = 1'b0;
    logic [6:0] i_table_index = '0;
    logic [6:0] i_table_value = '0;
    logic       i_cfg_valid = 1'b0;
    logic [1:0] i_cfg_index = '0;
    logic [6:0] i_cfg_data = '0;
    logic       o_busy, o_done, o_read_is_wall, o_cfg_ready;
    logic [1:0] o_done_opcode;
    logic [6:0] o_read_bits;

    hex_lattice_gas_step dut (.*);

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Predictor state: two grid buffers (bit 7 = obstacle), collision
    // table, live buffer select and the two size registers.
    // ---------------------------------------------------------------
    logic [7:0] grid_buf [2][NCELLS];
    logic [6:0] coll_tab [128];
    logic       live_sel;
    logic [6:0] width_reg, height_reg;

    t_item   pending_items[$];
    t_answer awaited[$];

    int mismatches = 0;
    int n_cmds = 0, n_steps = 0, n_reads = 0, n_cfg = 0;
    int cycles = 0;

    // Size registers: zero behaves as one, anything above the store as the store size
    function automatic int eff_size(input logic [6:0] v, input int max);
        if (v == 0) return 1;
        if (v > max) return max;
        return v;
    endfunction

    // One lattice step: copy, collide through the table, stream, then inject at column 0
    task automatic lattice_step();
        int w, h, i, nx, ny, odd;
        logic [6:0] st;
        logic [6:0] back;
        logic src, dst;
        src = live_sel;
        dst = ~live_sel;
        w = eff_size(width_reg, GW);
        h = eff_size(height_reg, GH);
        for (int y = 0; y < GH; y++)
            for (int x = 0; x < GW; x++) begin
                i = y * GW + x;
                grid_buf[dst][i] = (x < w && y < h) ? (grid_buf[src][i] & 8'h80)
                                                    : grid_buf[src][i];
            end
        for (int y = 0; y < h; y++) begin
            odd = y & 1;
            for (int x = 0; x < w; x++) begin
                i = y * GW + x;
                if (grid_buf[src][i][7]) continue;      // obstacles emit nothing
                st = coll_tab[grid_buf[src][i][6:0]];
                if (st[6]) grid_buf[dst][i][6] = 1'b1;  // rest particle stays put
                for (int d = 0; d < 6; d++) begin
                    if (!st[d]) continue;
                    back = 7'(1 << ((d + 3) % 6));
                    nx = x;
                    ny = y;
                    case (d)
                        0: nx = x + 1;
                        1: begin nx = x + odd;     ny = y - 1; end
                        2: begin nx = x + odd - 1; ny = y - 1; end
                        3: nx = x - 1;
                        4: begin nx = x + odd - 1; ny = y + 1; end
                        default: begin nx = x + odd; ny = y + 1; end
                    endcase
                    if (ny < 0 || ny >= h) begin
                        // top/bottom edge reflects
                        grid_buf[dst][i][6:0] |= back;
                        continue;
                    end
                    if (nx < 0 || nx >= w) continue;   // lost past left/right
                    if (grid_buf[dst][ny * GW + nx][7])
                        grid_buf[dst][i][6:0] |= back; // bounce off obstacle
                    else
                        grid_buf[dst][ny * GW + nx][d] = 1'b1;
                end
            end
        end
        for (int y = 0; y < h; y++)
            if (!grid_buf[dst][y * GW][7])
                grid_buf[dst][y * GW][6:0] |= hlg_pkg::INJECT_MASK;
        live_sel = dst;
    endtask

    // Apply an accepted command and return what the block should answer
    task automatic run_command(input t_item it, output t_answer ans);
        logic [7:0] c;
        ans.op = it.op;
        ans.bits = '0;
        ans.wall = 1'b0;
        case (it.op)
            hlg_pkg::OP_TBL_WR:  coll_tab[it.tidx] = it.tval;
            hlg_pkg::OP_CELL_WR: grid_buf[live_sel][it.y * GW + it.x] = {it.wall, it.bits};
            hlg_pkg::OP_STEP:    begin lattice_step(); n_steps++; end
            default: begin
                c = grid_buf[live_sel][it.y * GW + it.x];
                ans.bits = c[6:0];
                ans.wall = c[7];
                n_reads++;
            end
        endcase
    endtask

    // ---------------------------------------------------------------
    // Driver: bursts of items with random gaps; register writes and
    // pressure pauses wait until every awaited result has come.
    // ---------------------------------------------------------------
    int    gap = 0;
    int    burst = 4;
    t_item cur_item;

    always @(posedge i_clk) begin
        logic    nstart, ncfg;
        t_item   head;
        t_answer ans;
        if (!i_rst_n) begin
            i_start <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            nstart = i_start;
            ncfg = i_cfg_valid;
            if (i_start && !o_busy) begin
                run_command(cur_item, ans);
                awaited.push_back(ans);
                n_cmds++;
                nstart = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == hlg_pkg::CFG_WIDTH) width_reg = i_cfg_data;
                else if (i_cfg_index == hlg_pkg::CFG_HEIGHT) height_reg = i_cfg_data;
                n_cfg++;
                ncfg = 1'b0;
            end
            if (!nstart && !ncfg) begin
                if (gap > 0) begin
                    gap--;
                end else if (pending_items.size() > 0) begin
                    head = pending_items[0];
                    case (head.kind)
                        K_CMD: begin
                            void'(pending_items.pop_front());
                            cur_item = head;
                            i_opcode <= head.op;
                            i_cell_x <= head.x;
                            i_cell_y <= head.y;
                            i_cell_bits <= head.bits;
                            i_cell_is_wall <= head.wall;
                            i_table_index <= head.tidx;
                            i_table_value <= head.tval;
                            nstart = 1'b1;
                            burst--;
                            if (burst <= 0) begin
                                burst = $urandom_range(1, 12);
                                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                            end
                        end
                        K_CFG: begin
                            if (awaited.size() == 0 && !o_busy) begin
                                void'(pending_items.pop_front());
                                i_cfg_index <= head.reg_idx;
                                i_cfg_data <= head.reg_data;
                                ncfg = 1'b1;
                            end
                        end
                        default: begin
                            // pressure pause: let the block empty out
                            if (awaited.size() == 0)
                                void'(pending_items.pop_front());
                        end
                    endcase
                end
            end
            i_start <= nstart;
            i_cfg_valid <= ncfg;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: every strobed result against the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_answer exp_ans;
        if (i_rst_n && o_done) begin
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result op=%0d bits=%h wall=%b",
                             o_done_opcode, o_read_bits, o_read_is_wall);
            end else begin
                exp_ans = awaited.pop_front();
                if (o_done_opcode !== exp_ans.op || o_read_bits !== exp_ans.bits ||
                    o_read_is_wall !== exp_ans.wall) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp op=%0d bits=%h wall=%b, got op=%0d bits=%h wall=%b",
                                 exp_ans.op, exp_ans.bits, exp_ans.wall,
                                 o_done_opcode, o_read_bits, o_read_is_wall);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb NOT OK");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus planning. A shadow of buffer validity keeps every read
    // on cells that were written; every cell a step collides holds one
    // of the patterns whose table entry was loaded.
    // ---------------------------------------------------------------
    bit   gen_valid [2][NCELLS];
    bit   gen_sel = 1'b0;
    int   gen_w = GW, gen_h = GH;

    logic [6:0] pat [NPAT] = '{7'h00, 7'h7f, 7'h01, 7'h09, 7'h12, 7'h24,
                               7'h49, 7'h36, 7'h2a, 7'h15, 7'h40, 7'h3f};

    task automatic push_cmd(input hlg_pkg::t_opcode op, input int x, input int y,
                            input logic [6:0] bits, input logic wall,
                            input logic [6:0] ti, input logic [6:0] tv);
        t_item it;
        it.kind = K_CMD;
        it.op = op;
        it.x = 6'(x);
        it.y = 6'(y);
        it.bits = bits;
        it.wall = wall;
        it.tidx = ti;
        it.tval = tv;
        it.reg_idx = '0;
        it.reg_data = '0;
        pending_items.push_back(it);
        if (op == hlg_pkg::OP_CELL_WR) gen_valid[gen_sel][y * GW + x] = 1'b1;
        if (op == hlg_pkg::OP_STEP) begin
            for (int i = 0; i < NCELLS; i++) gen_valid[~gen_sel][i] = gen_valid[gen_sel][i];
            gen_sel = ~gen_sel;
        end
    endtask

    task automatic push_ctl(input t_kind k, input logic [1:0] idx, input logic [6:0] data);
        t_item it;
        it.kind = k;
        it.op = hlg_pkg::OP_TBL_WR;
        it.x = '0;
        it.y = '0;
        it.bits = '0;
        it.wall = 1'b0;
        it.tidx = '0;
        it.tval = '0;
        it.reg_idx = idx;
        it.reg_data = data;
        pending_items.push_back(it);
        if (k == K_CFG && idx == hlg_pkg::CFG_WIDTH) gen_w = eff_size(data, GW);
        if (k == K_CFG && idx == hlg_pkg::CFG_HEIGHT) gen_h = eff_size(data, GH);
    endtask

    task automatic push_read_valid();
        int x, y;
        x = $urandom_range(0, GW - 1);
        y = $urandom_range(0, GH - 1);
        if (!gen_valid[gen_sel][y * GW + x]) begin
            x = $urandom_range(0, gen_w - 1);
            y = $urandom_range(0, gen_h - 1);
        end
        push_cmd(hlg_pkg::OP_CELL_RD, x, y, 7'($urandom), 1'($urandom),
                 7'($urandom), 7'($urandom));
    endtask

    int phase_w [5] = '{0, 3, 2, 5, 1};
    int phase_h [5] = '{2, 3, 5, 2, 1};

    initial begin
        int n, r, x, y;
        // Directed: table entries for the cell patterns (value extremes), extreme cells
        for (int t = 0; t < NPAT; t++) begin
            r = (t == 0) ? 0 : (t == 1) ? 127 : $urandom_range(0, 127);
            push_cmd(hlg_pkg::OP_TBL_WR, 0, 0, 7'h00, 1'b0, pat[t], 7'(r));
        end
        push_cmd(hlg_pkg::OP_CELL_WR, 0, 0, 7'h00, 1'b0, 7'h00, 7'h00);
        push_cmd(hlg_pkg::OP_CELL_WR, 63, 63, 7'h7f, 1'b1, 7'h7f, 7'h7f);
        push_cmd(hlg_pkg::OP_CELL_WR, 63, 0, 7'h55, 1'b0, 7'h00, 7'h00);
        push_cmd(hlg_pkg::OP_CELL_WR, 0, 63, 7'h2a, 1'b1, 7'h00, 7'h00);
        push_cmd(hlg_pkg::OP_CELL_RD, 0, 0, 7'h7f, 1'b1, 7'h7f, 7'h7f);
        push_cmd(hlg_pkg::OP_CELL_RD, 63, 63, 7'h00, 1'b0, 7'h00, 7'h00);
        push_cmd(hlg_pkg::OP_CELL_RD, 63, 0, 7'h00, 1'b0, 7'h00, 7'h00);
        push_cmd(hlg_pkg::OP_CELL_RD, 0, 63, 7'h00, 1'b0, 7'h00, 7'h00);

        // Phases through size settings; each fills its in-use area, then steps once
        for (int p = 0; p < 5; p++) begin
            push_ctl(K_CFG, hlg_pkg::CFG_WIDTH, 7'(phase_w[p]));
            push_ctl(K_CFG, hlg_pkg::CFG_HEIGHT, 7'(phase_h[p]));
            for (y = 0; y < gen_h; y++)
                for (x = 0; x < gen_w; x++)
                    push_cmd(hlg_pkg::OP_CELL_WR, x, y, pat[$urandom_range(0, NPAT - 1)],
                             ($urandom_range(0, 4) == 0), 7'($urandom), 7'($urandom));
            push_cmd(hlg_pkg::OP_STEP, 0, 0, 7'($urandom), 1'($urandom),
                     7'($urandom), 7'($urandom));
            push_cmd(hlg_pkg::OP_CELL_RD, 0, 0, 7'h00, 1'b0, 7'h00, 7'h00);
            push_cmd(hlg_pkg::OP_CELL_RD, gen_w - 1, gen_h - 1, 7'h00, 1'b0, 7'h00, 7'h00);
            n = 6;
            for (int k = 0; k < n; k++) begin
                if (k == n / 2) push_ctl(K_DRAIN, 2'd0, 7'd0);
                r = $urandom_range(0, 99);
                if (r < 25)
                    push_cmd(hlg_pkg::OP_TBL_WR, 0, 0, 7'($urandom), 1'($urandom),
                             7'($urandom), 7'($urandom));
                else if (r < 55) begin
                    // mostly inside the area in use, sometimes anywhere
                    if ($urandom_range(0, 2) == 0) begin
                        x = $urandom_range(0, GW - 1);
                        y = $urandom_range(0, GH - 1);
                    end else begin
                        x = $urandom_range(0, gen_w - 1);
                        y = $urandom_range(0, gen_h - 1);
                    end
                    push_cmd(hlg_pkg::OP_CELL_WR, x, y, 7'($urandom),
                             ($urandom_range(0, 3) == 0), 7'($urandom), 7'($urandom));
                end else
                    push_read_valid();
            end
            for (int k = 0; k < 2; k++) push_read_valid();
        end

        live_sel = 1'b0;
        width_reg = 7'd64;
        height_reg = 7'd64;
        for (int t = 0; t < 128; t++) coll_tab[t] = '0;
        for (int i = 0; i < NCELLS; i++) begin
            grid_buf[0][i] = '0;
            grid_buf[1][i] = '0;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (pending_items.size() > 0 || i_start || i_cfg_valid || awaited.size() > 0)
            @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);

        $display("ran %0d commands (%0d steps, %0d reads) and %0d register writes",
                 n_cmds, n_steps, n_reads, n_cfg);
        $display("%0d mismatches in %0d cycles", mismatches, cycles);
        if (mismatches == 0 && awaited.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/hlg_pkg.sv
rtl/core/hlg_grid_ram.sv
rtl/core/hlg_ctable.sv
rtl/core/hlg_nbr.sv
rtl/core/hlg_seq.sv
rtl/core/hex_lattice_gas_step.sv
tb/tb.sv
